[rtl/core/sparc_integer_alu_with_flags_assert.svh]
// Assertion macros for the integer ALU.
`ifndef SPARC_INTEGER_ALU_WITH_FLAGS_ASSERT_SVH
`define SPARC_INTEGER_ALU_WITH_FLAGS_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define SIA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SIA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/core/sia_pkg.sv]
// Package: operation codes, widths and shared types for the integer ALU.
package sia_pkg;
    localparam logic [4:0] OP_ADD = 5'd0, OP_ADDC = 5'd1, OP_ADDCC = 5'd2,
        OP_ADDCCC = 5'd3, OP_ADDX = 5'd4, OP_ADDXC = 5'd5, OP_ADDXCC = 5'd6,
        OP_ADDXCCC = 5'd7, OP_SUB = 5'd8, OP_SUBCC = 5'd9, OP_SUBC = 5'd10,
        OP_SUBCCC = 5'd11, OP_TADDCC = 5'd12, OP_TADDCCTV = 5'd13,
        OP_TSUBCCTV = 5'd14, OP_SMUL = 5'd15, OP_SMULCC = 5'd16, OP_UMUL = 5'd17,
        OP_UMULCC = 5'd18, OP_MULX = 5'd19, OP_SDIV = 5'd20, OP_SDIVCC = 5'd21,
        OP_UDIV = 5'd22, OP_UDIVCC = 5'd23, OP_SDIVX = 5'd24, OP_UDIVX = 5'd25,
        OP_MULSCC = 5'd26;
    localparam logic [1:0] TRAP_NONE = 2'd0, TRAP_TAG_ADD = 2'd1,
        TRAP_TAG_SUB = 2'd2, TRAP_DIV_ZERO = 2'd3;
    localparam int W = 64;
    localparam int CW = 7;

    // start command to the iterative unit
    typedef struct packed {
        logic        start;
        logic        is_div;
    } t_iter_cmd;

    // status back from the iterative unit
    typedef struct packed {
        logic        busy;
        logic        done;
    } t_iter_sts;

    function automatic logic [3:0] nzvc32(input logic [63:0] r, input logic v,
                                          input logic c);
        nzvc32 = {r[31], r[31:0] == 32'd0, v, c};
    endfunction

    function automatic logic [3:0] nzvc64(input logic [63:0] r, input logic v,
                                          input logic c);
        nzvc64 = {r[63], r == 64'd0, v, c};
    endfunction
endpackage

[rtl/core/sparc_integer_alu_with_flags.sv]
// Top level: SPARC64 integer ALU with icc, xcc and Y, sequenced over a shared unit.
// channel | direction | handshake              | payload
// in      | input     | i_valid / o_ready      | i_action, i_operand_a, i_operand_b
// out     | output    | o_valid / i_ready      | o_result .. o_y_out
// Add, subtract, tagged ops and MULScc are computed in S_EXEC and registered for S_OUT.
// Multiplies and divides run 64 steps of the shift-add/subtract unit; a divide by zero traps without starting it.
// Result sits in an output register; next transaction is taken the cycle after delivery.
// Synchronous active-low reset clears flags, Y and control.
module sparc_integer_alu_with_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_action,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result,
    output logic        o_result_valid,
    output logic [1:0]  o_trap_kind,
    output logic [3:0]  o_icc_out,
    output logic [3:0]  o_xcc_out,
    output logic [31:0] o_y_out
);
    localparam logic [1:0] S_IDLE = 2'd0, S_EXEC = 2'd1, S_WAIT = 2'd2, S_OUT = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [4:0]  r_act;
    logic [63:0] r_a, r_b;
    logic [3:0]  r_icc, n_icc, r_xcc, n_xcc;
    logic [31:0] r_y, n_y;
    logic [63:0] r_res, n_res;
    logic        r_rv, n_rv;
    logic [1:0]  r_trap, n_trap;
    logic        r_na, r_nb;

    sia_pkg::t_iter_cmd w_cmd;
    sia_pkg::t_iter_sts w_sts;
    logic [63:0] w_ix, w_iy, w_ires;
    logic        w_start, w_is_div;

    logic        w_cin;
    logic [63:0] w_addb, w_sum, w_nb, w_dif, w_s1, w_s2, w_ms, w_q;
    logic [64:0] w_dn;
    logic        w_tag, w_ov;

    sia_iter u_iter (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .i_x    (w_ix),
        .i_y    (w_iy),
        .o_sts  (w_sts),
        .o_res  (w_ires)
    );

    function automatic logic [3:0] add_fl(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] r, input logic top);
        logic [63:0] c, v;
        c = (a & b) | ((a | b) & ~r);
        v = (a ^ r) & (b ^ r);
        add_fl = top ? sia_pkg::nzvc64(r, v[63], c[63]) : sia_pkg::nzvc32(r, v[31], c[31]);
    endfunction

    function automatic logic [3:0] sub_fl(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] r, input logic top);
        logic [63:0] c, v;
        c = (~a & b) | ((~a | b) & r);
        v = (a ^ b) & (a ^ r);
        sub_fl = top ? sia_pkg::nzvc64(r, v[63], c[63]) : sia_pkg::nzvc32(r, v[31], c[31]);
    endfunction

    assign w_cmd          = {w_start, w_is_div};
    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_result       = r_res;
    assign o_result_valid = r_rv;
    assign o_trap_kind    = r_trap;
    assign o_icc_out      = r_icc;
    assign o_xcc_out      = r_xcc;
    assign o_y_out        = r_y;

    // operand set-up for the shared unit, taken from the transaction registers
    always_comb begin
        w_is_div = 1'b0;
        w_ix = r_a;
        w_iy = r_b;
        case (r_act)
            sia_pkg::OP_SMUL, sia_pkg::OP_SMULCC: begin
                w_ix = {{32{r_a[31]}}, r_a[31:0]};
                w_iy = {{32{r_b[31]}}, r_b[31:0]};
            end
            sia_pkg::OP_UMUL, sia_pkg::OP_UMULCC: begin
                w_ix = {32'd0, r_a[31:0]};
                w_iy = {32'd0, r_b[31:0]};
            end
            sia_pkg::OP_SDIV, sia_pkg::OP_SDIVCC: begin
                w_is_div = 1'b1;
                w_ix = r_y[31] ? 64'd0 - {r_y, r_a[31:0]} : {r_y, r_a[31:0]};
                w_iy = r_b[31] ? 64'd0 - {{32{r_b[31]}}, r_b[31:0]}
                               : {32'd0, r_b[31:0]};
            end
            sia_pkg::OP_UDIV, sia_pkg::OP_UDIVCC: begin
                w_is_div = 1'b1;
                w_ix = {r_y, r_a[31:0]};
                w_iy = {32'd0, r_b[31:0]};
            end
            sia_pkg::OP_SDIVX: begin
                w_is_div = 1'b1;
                w_ix = r_a[63] ? 64'd0 - r_a : r_a;
                w_iy = r_b[63] ? 64'd0 - r_b : r_b;
            end
            sia_pkg::OP_UDIVX: begin
                w_is_div = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_icc   = r_icc;
        n_xcc   = r_xcc;
        n_y     = r_y;
        n_res   = r_res;
        n_rv    = r_rv;
        n_trap  = r_trap;
        w_cin   = (r_act == sia_pkg::OP_ADDXC || r_act == sia_pkg::OP_ADDXCCC)
                  ? r_xcc[0] : r_icc[0];
        w_addb  = '0;
        w_sum   = r_a + r_b;
        w_nb    = r_a - r_b;
        w_dif   = w_nb;
        w_tag   = (r_a[1:0] | r_b[1:0]) != 2'd0;
        w_ov    = 1'b0;
        w_s1    = {32'd0, (r_icc[3] ^ r_icc[1]), r_a[31:1]};
        w_s2    = r_y[0] ? {32'd0, r_b[31:0]} : 64'd0;
        w_ms    = {32'd0, w_s1[31:0] + w_s2[31:0]};
        w_q     = w_ires;
        w_dn    = '0;
        w_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_rv    = 1'b1;
                n_trap  = sia_pkg::TRAP_NONE;
                n_res   = '0;
                n_state = S_OUT;
                case (r_act)
                    sia_pkg::OP_ADD, sia_pkg::OP_ADDX, sia_pkg::OP_ADDXCC,
                    sia_pkg::OP_ADDCC: begin
                        n_res = w_sum;
                        if (r_act == sia_pkg::OP_ADDXCC || r_act == sia_pkg::OP_ADDCC) begin
                            n_icc = add_fl(r_a, r_b, w_sum, 1'b0);
                            n_xcc = add_fl(r_a, r_b, w_sum, 1'b1);
                        end
                    end
                    sia_pkg::OP_ADDC, sia_pkg::OP_ADDXC, sia_pkg::OP_ADDCCC,
                    sia_pkg::OP_ADDXCCC: begin
                        w_addb = w_sum + {63'd0, w_cin};
                        n_res  = w_addb;
                        if (r_act == sia_pkg::OP_ADDCCC || r_act == sia_pkg::OP_ADDXCCC) begin
                            n_icc = add_fl(r_a, r_b, w_addb, 1'b0);
                            n_xcc = add_fl(r_a, r_b, w_addb, 1'b1);
                        end
                    end
                    sia_pkg::OP_SUB: n_res = w_nb;
                    sia_pkg::OP_SUBCC: begin
                        n_res = w_nb;
                        n_icc = sub_fl(r_a, r_b, w_nb, 1'b0);
                        n_xcc = sub_fl(r_a, r_b, w_nb, 1'b1);
                    end
                    sia_pkg::OP_SUBC, sia_pkg::OP_SUBCCC: begin
                        w_dif = w_nb - {63'd0, w_cin};
                        n_res = w_dif;
                        if (r_act == sia_pkg::OP_SUBCCC) begin
                            n_icc = sub_fl(r_a, r_b, w_dif, 1'b0);
                            n_xcc = sub_fl(r_a, r_b, w_dif, 1'b1);
                        end
                    end
                    sia_pkg::OP_TADDCC, sia_pkg::OP_TADDCCTV: begin
                        w_ov = (r_a[31] ^ w_sum[31]) & (r_b[31] ^ w_sum[31]);
                        if (r_act == sia_pkg::OP_TADDCCTV && (w_tag || w_ov)) begin
                            n_rv   = 1'b0;
                            n_trap = sia_pkg::TRAP_TAG_ADD;
                        end else begin
                            n_res = w_sum;
                            n_icc = add_fl(r_a, r_b, w_sum, 1'b0) | {2'b00, w_tag, 1'b0};
                            n_xcc = add_fl(r_a, r_b, w_sum, 1'b1);
                        end
                    end
                    sia_pkg::OP_TSUBCCTV: begin
                        w_ov = (r_a[31] ^ r_b[31]) & (r_a[31] ^ w_nb[31]);
                        if (w_tag || w_ov) begin
                            n_rv   = 1'b0;
                            n_trap = sia_pkg::TRAP_TAG_SUB;
                        end else begin
                            n_res = w_nb;
                            n_icc = sub_fl(r_a, r_b, w_nb, 1'b0);
                            n_xcc = sub_fl(r_a, r_b, w_nb, 1'b1);
                        end
                    end
                    sia_pkg::OP_SMUL, sia_pkg::OP_SMULCC, sia_pkg::OP_UMUL,
                    sia_pkg::OP_UMULCC, sia_pkg::OP_MULX: begin
                        w_start = 1'b1;
                        n_state = S_WAIT;
                    end
                    sia_pkg::OP_SDIV, sia_pkg::OP_SDIVCC, sia_pkg::OP_UDIV,
                    sia_pkg::OP_UDIVCC: begin
                        if (r_b[31:0] == 32'd0) begin
                            n_rv   = 1'b0;
                            n_trap = sia_pkg::TRAP_DIV_ZERO;
                        end else begin
                            w_start = 1'b1;
                            n_state = S_WAIT;
                        end
                    end
                    sia_pkg::OP_SDIVX, sia_pkg::OP_UDIVX: begin
                        if (r_b == 64'd0) begin
                            n_rv   = 1'b0;
                            n_trap = sia_pkg::TRAP_DIV_ZERO;
                        end else begin
                            w_start = 1'b1;
                            n_state = S_WAIT;
                        end
                    end
                    sia_pkg::OP_MULSCC: begin
                        n_res = w_ms;
                        n_y   = {r_a[0], r_y[31:1]};
                        n_icc = add_fl(w_s1, w_s2, w_ms, 1'b0);
                        n_xcc = 4'd0;
                    end
                    default: n_rv = 1'b0;
                endcase
            end
            S_WAIT: begin
                if (w_sts.done) begin
                    n_state = S_OUT;
                    n_res   = w_q;
                    case (r_act)
                        sia_pkg::OP_SMUL, sia_pkg::OP_SMULCC, sia_pkg::OP_UMUL,
                        sia_pkg::OP_UMULCC: begin
                            n_y = w_q[63:32];
                            if (r_act == sia_pkg::OP_SMULCC || r_act == sia_pkg::OP_UMULCC) begin
                                n_icc = sia_pkg::nzvc32(w_q, 1'b0, 1'b0);
                                n_xcc = sia_pkg::nzvc64(w_q, 1'b0, 1'b0);
                            end
                        end
                        sia_pkg::OP_SDIV, sia_pkg::OP_SDIVCC: begin
                            if (r_na != r_nb) begin
                                w_ov  = w_q > 64'h8000_0000;
                                w_dn  = {1'b0, 64'd0 - (w_ov ? 64'h8000_0000 : w_q)};
                                n_res = {{32{w_dn[31]}}, w_dn[31:0]};
                            end else begin
                                w_ov  = w_q > 64'h7fff_ffff;
                                n_res = w_ov ? 64'h7fff_ffff : w_q;
                            end
                            if (r_act == sia_pkg::OP_SDIVCC) begin
                                n_icc = sia_pkg::nzvc32(n_res, w_ov, 1'b0);
                                n_xcc = sia_pkg::nzvc64(n_res, 1'b0, 1'b0);
                            end
                        end
                        sia_pkg::OP_UDIV, sia_pkg::OP_UDIVCC: begin
                            w_ov  = w_q[63:32] != 32'd0;
                            n_res = w_ov ? 64'hffff_ffff : w_q;
                            if (r_act == sia_pkg::OP_UDIVCC) begin
                                n_icc = sia_pkg::nzvc32(n_res, w_ov, 1'b0);
                                n_xcc = sia_pkg::nzvc64(n_res, 1'b0, 1'b0);
                            end
                        end
                        sia_pkg::OP_SDIVX: n_res = (r_na != r_nb) ? 64'd0 - w_q : w_q;
                        default: ;
                    endcase
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_icc   <= '0;
            r_xcc   <= '0;
            r_y     <= '0;
        end else begin
            r_state <= n_state;
            r_icc   <= n_icc;
            r_xcc   <= n_xcc;
            r_y     <= n_y;
        end
        r_res  <= n_res;
        r_rv   <= n_rv;
        r_trap <= n_trap;
        if (i_valid && o_ready) begin
            r_act <= i_action;
            r_a   <= i_operand_a;
            r_b   <= i_operand_b;
        end
        if (r_state == S_EXEC) begin
            case (r_act)
                sia_pkg::OP_SDIV, sia_pkg::OP_SDIVCC: begin
                    r_na <= r_y[31];
                    r_nb <= r_b[31];
                end
                default: begin
                    r_na <= r_a[63];
                    r_nb <= r_b[63];
                end
            endcase
        end
    end

`include "sparc_integer_alu_with_flags_assert.svh"
    `SIA_ASSERT_IMP(a_ready_not_out, i_clk, i_rst_n, o_valid, !o_ready)
    `SIA_ASSERT_IMP(a_trap_no_write, i_clk, i_rst_n, o_valid && o_trap_kind != sia_pkg::TRAP_NONE, !o_result_valid)
    `SIA_ASSERT_NXT(a_trap_keeps_flags, i_clk, i_rst_n, r_state == S_EXEC && n_trap != sia_pkg::TRAP_NONE, $stable(r_icc) && $stable(r_y))
endmodule

[rtl/core/sia_iter.sv]
// Shared shift-add / shift-subtract unit: 64-bit multiply and divide, one bit a cycle.
module sia_iter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sia_pkg::t_iter_cmd   i_cmd,
    input  logic [63:0]          i_x,
    input  logic [63:0]          i_y,
    output sia_pkg::t_iter_sts   o_sts,
    output logic [63:0]          o_res
);
    logic [sia_pkg::CW-1:0] r_cnt, n_cnt;
    logic                   r_busy, n_busy, r_done, n_done, r_div, n_div;
    logic [63:0]            r_acc, n_acc, r_x, n_x, r_y, n_y;
    logic [64:0]            w_diff;
    logic [63:0]            w_rem;

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_div  = r_div;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        w_rem  = '0;
        w_diff = '0;
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_div  = i_cmd.is_div;
            n_cnt  = '0;
            n_acc  = '0;
            n_x    = i_x;
            n_y    = i_y;
        end else if (r_busy) begin
            if (r_div) begin
                // r_acc remainder, r_x dividend shifting into quotient
                w_rem  = {r_acc[62:0], r_x[63]};
                w_diff = {1'b0, w_rem} - {1'b0, r_y};
                if (r_acc[63] || !w_diff[64]) begin
                    n_acc = w_diff[63:0];
                    n_x   = {r_x[62:0], 1'b1};
                end else begin
                    n_acc = w_rem;
                    n_x   = {r_x[62:0], 1'b0};
                end
            end else begin
                if (r_y[0]) begin
                    n_acc = r_acc + r_x;
                end
                n_x = {r_x[62:0], 1'b0};
                n_y = {1'b0, r_y[63:1]};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == sia_pkg::CW'(sia_pkg::W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_div <= n_div;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_res      = r_div ? r_x : r_acc;

`include "sparc_integer_alu_with_flags_assert.svh"
    `SIA_ASSERT_NXT(a_done_after_last, i_clk, i_rst_n, r_busy && !i_cmd.start && r_cnt == sia_pkg::CW'(sia_pkg::W - 1), r_done && !r_busy)
    `SIA_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, r_done, !r_busy)
    `SIA_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_cmd.start, r_busy && r_cnt == '0)
endmodule
